// ===== hdl/soc_pkg.sv =====
package soc_pkg;

  // Field widths
  localparam int BYTE_W          = 8;
  localparam int PAT_BYTES       = 16;
  localparam int PAT_W           = PAT_BYTES * BYTE_W;
  localparam int LEN_W           = 5;
  localparam int SKIP_W          = 4;
  localparam int TALLY_W         = 32;
  localparam int CFG_DATA_W      = 64;
  localparam int CFG_IDX_W       = 3;
  localparam int OUT_TDATA_W     = 40;
  localparam int OUT_PAD_W       = OUT_TDATA_W - 1 - TALLY_W;

  // Default window depth
  localparam int PATTERN_MAX_DEF = 16;

  // ASCII letters used by case folding
  localparam logic [BYTE_W-1:0] ASCII_UPPER_A = 8'h41;
  localparam logic [BYTE_W-1:0] ASCII_UPPER_Z = 8'h5A;
  localparam logic [BYTE_W-1:0] ASCII_LOWER_A = 8'h61;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PATTERN_LOW  = 3'd0,
    CFG_PATTERN_HIGH = 3'd1,
    CFG_PATTERN_LEN  = 3'd2,
    CFG_CASE_SENS    = 3'd3,
    CFG_NON_OVERLAP  = 3'd4
  } cfg_sel_t;

  // Settings seen by the match core
  typedef struct packed {
    logic [PAT_W-1:0] pattern;
    logic [LEN_W-1:0] len;
    logic             case_sens;
    logic             non_ovl;
  } cfg_t;

  // One text word held in the input register
  typedef struct packed {
    logic [BYTE_W-1:0] text_byte;
    logic              last;
  } item_t;

  // Fold A-Z to lower case when requested
  function automatic logic [BYTE_W-1:0] fold_case(input logic [BYTE_W-1:0] b,
                                                  input logic fold);
    logic [BYTE_W-1:0] res;
    res = b;
    if (fold && (b >= ASCII_UPPER_A) && (b <= ASCII_UPPER_Z)) begin
      res = b + (ASCII_LOWER_A - ASCII_UPPER_A);
    end
    return res;
  endfunction

endpackage

// ===== hdl/soc_cfg_regs.sv =====
module soc_cfg_regs (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [soc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [soc_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  output soc_pkg::cfg_t                   cfg
);

  soc_pkg::cfg_t cfg_r;

  // Write the addressed register; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.pattern   <= '0;
      cfg_r.len       <= '0;
      cfg_r.case_sens <= 1'b1;
      cfg_r.non_ovl   <= 1'b0;
    end else if (cfg_we) begin
      case (soc_pkg::cfg_sel_t'(cfg_index))
        soc_pkg::CFG_PATTERN_LOW:
          cfg_r.pattern[soc_pkg::CFG_DATA_W-1:0] <= cfg_wdata;
        soc_pkg::CFG_PATTERN_HIGH:
          cfg_r.pattern[soc_pkg::PAT_W-1:soc_pkg::CFG_DATA_W] <= cfg_wdata;
        soc_pkg::CFG_PATTERN_LEN:
          cfg_r.len <= cfg_wdata[soc_pkg::LEN_W-1:0];
        soc_pkg::CFG_CASE_SENS:
          cfg_r.case_sens <= cfg_wdata[0];
        soc_pkg::CFG_NON_OVERLAP:
          cfg_r.non_ovl <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

// ===== hdl/soc_in_reg.sv =====
module soc_in_reg (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  input  logic [soc_pkg::BYTE_W-1:0]  in_tdata,
  input  logic                        in_tlast,
  input  logic                        core_ready,
  output logic                        item_valid,
  output soc_pkg::item_t              item
);

  logic           valid_r;
  soc_pkg::item_t item_r;

  // Take a new word whenever the held one is empty or moves on this cycle
  assign in_tready = !valid_r || core_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_tready) begin
      valid_r <= in_tvalid;
    end
  end

  // Hold the payload until the core consumes it
  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      item_r.text_byte <= in_tdata;
      item_r.last      <= in_tlast;
    end
  end

  assign item_valid = valid_r;
  assign item       = item_r;

endmodule

// ===== hdl/soc_match_core.sv =====
module soc_match_core #(
  parameter int PATTERN_MAX = soc_pkg::PATTERN_MAX_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  soc_pkg::cfg_t                 cfg,
  input  logic                          item_valid,
  input  soc_pkg::item_t                item,
  output logic                          core_ready,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          out_hit,
  output logic [soc_pkg::TALLY_W-1:0]   out_total,
  output logic                          out_last
);

  localparam int SEEN_W = $clog2(PATTERN_MAX + 1);
  localparam int LEN_W  = soc_pkg::LEN_W;

  logic [soc_pkg::BYTE_W-1:0]  win_r   [PATTERN_MAX];
  logic [soc_pkg::BYTE_W-1:0]  win_nxt [PATTERN_MAX];
  logic [soc_pkg::BYTE_W-1:0]  tsel    [PATTERN_MAX];
  logic [PATTERN_MAX-1:0]      pos_ok;
  logic [SEEN_W-1:0]           seen_r, seen_nxt, seen_inc;
  logic [soc_pkg::SKIP_W-1:0]  skip_r, skip_nxt;
  logic [soc_pkg::TALLY_W-1:0] tally_r, tally_nxt;
  logic                        len_ok, cand, hit;
  logic                        fire;
  logic                        out_valid_r, out_hit_r, out_last_r;
  logic [soc_pkg::TALLY_W-1:0] out_total_r;

  // Advance when the result register is free or being drained
  assign core_ready = !out_valid_r || out_ready;
  assign fire       = item_valid && core_ready;

  // Shift the new byte into the window
  always_comb begin
    win_nxt[0] = item.text_byte;
    for (int k = 1; k < PATTERN_MAX; k++) begin
      win_nxt[k] = win_r[k-1];
    end
  end

  assign seen_inc = (seen_r < SEEN_W'(PATTERN_MAX)) ? seen_r + 1'b1 : seen_r;

  assign len_ok = (cfg.len != '0) && (cfg.len <= LEN_W'(PATTERN_MAX)) &&
                  (LEN_W'(seen_inc) >= cfg.len);

  // Compare every pattern position against its window byte in parallel
  always_comb begin
    for (int j = 0; j < PATTERN_MAX; j++) begin
      tsel[j] = '0;
      for (int k = 0; k < PATTERN_MAX; k++) begin
        if ((LEN_W+1)'(k + j + 1) == {1'b0, cfg.len}) begin
          tsel[j] = win_nxt[k];
        end
      end
      pos_ok[j] = (LEN_W'(j) >= cfg.len) ||
                  (soc_pkg::fold_case(tsel[j], !cfg.case_sens) ==
                   soc_pkg::fold_case(cfg.pattern[j*soc_pkg::BYTE_W +: soc_pkg::BYTE_W],
                                      !cfg.case_sens));
    end
  end

  assign cand = len_ok && (&pos_ok);

  // Skip window, tally and fill count
  always_comb begin
    hit       = cand;
    skip_nxt  = skip_r;
    tally_nxt = tally_r;
    if (skip_r != '0) begin
      hit      = 1'b0;
      skip_nxt = skip_r - 1'b1;
    end else if (cand) begin
      if (tally_r != '1) begin
        tally_nxt = tally_r + 1'b1;
      end
      if (cfg.non_ovl) begin
        skip_nxt = soc_pkg::SKIP_W'(cfg.len - 1'b1);
      end
    end
    seen_nxt = seen_inc;
  end

  // Update text state once per consumed word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_r  <= '0;
      skip_r  <= '0;
      tally_r <= '0;
    end else if (fire) begin
      if (item.last) begin
        seen_r  <= '0;
        skip_r  <= '0;
        tally_r <= '0;
      end else begin
        seen_r  <= seen_nxt;
        skip_r  <= skip_nxt;
        tally_r <= tally_nxt;
      end
    end
  end

  // Window bytes are only read once the fill count covers them
  always_ff @(posedge clk) begin
    if (fire) begin
      win_r <= win_nxt;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (core_ready) begin
      out_valid_r <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_hit_r   <= hit;
      out_total_r <= tally_nxt;
      out_last_r  <= item.last;
    end
  end

  assign out_valid = out_valid_r;
  assign out_hit   = out_hit_r;
  assign out_total = out_total_r;
  assign out_last  = out_last_r;

endmodule

// ===== hdl/substring_occurrence_counter_top.sv =====
// Channel   Dir  Handshake          Payload
// in_       in   tvalid / tready    tdata = text_byte, tlast = end_of_text
// out_      out  tvalid / tready    tdata = match_ends_here, match_total; tlast = text_done
// cfg_      in   cfg_we             cfg_index selects register, cfg_wdata carries value
//
// One text byte per cycle sustained while out_tready stays high; a result word is
// registered: its byte sits in the input register while the compare/count logic
// feeds the result register.
// Reset (rst_n low, synchronous) empties both registers, clears the window fill,
// skip and match counts, and sets the pattern empty and the compare exact.
// A stall on out_tready holds the result; the input register takes at most one more
// byte before in_tready drops.
module substring_occurrence_counter_top #(
  parameter int PATTERN_MAX = soc_pkg::PATTERN_MAX_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // Bits 7:0 text_byte
  input  logic [soc_pkg::BYTE_W-1:0]        in_tdata,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic                              in_tlast,
  // Bit 0 match_ends_here, bits 32:1 match_total, bits 39:33 zero
  output logic [soc_pkg::OUT_TDATA_W-1:0]   out_tdata,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic                              out_tlast,
  input  logic                              cfg_we,
  input  logic [soc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [soc_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

  soc_pkg::cfg_t               cfg;
  soc_pkg::item_t              item;
  logic                        item_valid;
  logic                        core_ready;
  logic                        out_hit;
  logic [soc_pkg::TALLY_W-1:0] out_total;

  soc_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  soc_in_reg u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .core_ready (core_ready),
    .item_valid (item_valid),
    .item       (item)
  );

  soc_match_core #(
    .PATTERN_MAX (PATTERN_MAX)
  ) u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .item_valid (item_valid),
    .item       (item),
    .core_ready (core_ready),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_hit    (out_hit),
    .out_total  (out_total),
    .out_last   (out_tlast)
  );

  // Pack the result word
  assign out_tdata = {{soc_pkg::OUT_PAD_W{1'b0}}, out_total, out_hit};

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps

module tb;

  localparam int WINDOW      = soc_pkg::PATTERN_MAX_DEF;
  localparam int QUIET_LIMIT = 2000;
  localparam int PHASES      = 12;
  localparam int PHASE_WORDS = 94;
  localparam logic [soc_pkg::BYTE_W-1:0] CASE_BIT =
    soc_pkg::ASCII_LOWER_A - soc_pkg::ASCII_UPPER_A;
  localparam logic [soc_pkg::BYTE_W-1:0] ASCII_LOWER_Z = soc_pkg::ASCII_LOWER_A + 8'd25;

  typedef struct packed {
    logic                        done;
    logic [soc_pkg::TALLY_W-1:0] total;
    logic                        hit;
  } match_result_t;

  typedef enum logic {ROW_WRITE, ROW_WORD} row_kind_t;

  // One line of the directed plan: a register write or a run of identical words
  typedef struct packed {
    row_kind_t                   kind;
    soc_pkg::cfg_sel_t           sel;
    logic [63:0]                 value;
    logic [soc_pkg::BYTE_W-1:0]  text;
    logic                        eot;
    logic [4:0]                  reps;
    logic                        typed;
    logic                        want_hit;
    logic [soc_pkg::TALLY_W-1:0] want_total;
  } plan_row_t;

  logic                            clk = 1'b0;
  logic                            rst_n = 1'b0;
  logic [soc_pkg::BYTE_W-1:0]      in_tdata = '0;
  logic                            in_tvalid = 1'b0;
  logic                            in_tready;
  logic                            in_tlast = 1'b0;
  logic [soc_pkg::OUT_TDATA_W-1:0] out_tdata;
  logic                            out_tvalid;
  logic                            out_tready = 1'b0;
  logic                            out_tlast;
  logic                            cfg_we = 1'b0;
  logic [soc_pkg::CFG_IDX_W-1:0]   cfg_index = soc_pkg::CFG_PATTERN_LOW;
  logic [soc_pkg::CFG_DATA_W-1:0]  cfg_wdata = '0;

  // Shadow of the programmed settings
  logic [soc_pkg::PAT_W-1:0]       pat_bytes = '0;
  logic [soc_pkg::LEN_W-1:0]       pat_len = '0;
  logic                            exact_cmp = 1'b1;
  logic                            no_overlap = 1'b0;

  // Shadow of the search state for the current text
  logic [soc_pkg::BYTE_W-1:0]      window_bytes [WINDOW] = '{default: '0};
  logic [soc_pkg::LEN_W-1:0]       fill_count = '0;
  logic [soc_pkg::SKIP_W-1:0]      skip_count = '0;
  logic [soc_pkg::TALLY_W-1:0]     match_count = '0;

  match_result_t         pending_results [$];
  int                    fail_count = 0;
  int                    quiet_cycles = 0;
  int                    src_idle_pct = 0;
  int                    sink_idle_pct = 0;
  plan_row_t             plan_rows [24];
  int                    phase_len [PHASES] = '{16, 1, 3, 0, 5, 16, 2, 31, 8, 4, 17, 1};

  substring_occurrence_counter_top uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tdata  (in_tdata),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tlast  (in_tlast),
    .out_tdata (out_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tlast (out_tlast),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always #5 clk = ~clk;

  function automatic logic [soc_pkg::BYTE_W-1:0] to_lower(
      input logic [soc_pkg::BYTE_W-1:0] b);
    if (b >= soc_pkg::ASCII_UPPER_A && b <= soc_pkg::ASCII_UPPER_Z) begin
      return b + CASE_BIT;
    end
    return b;
  endfunction

  function automatic logic [soc_pkg::BYTE_W-1:0] pick_letter();
    case ($urandom_range(3))
      0: return soc_pkg::ASCII_UPPER_A;
      1: return soc_pkg::ASCII_LOWER_A;
      2: return soc_pkg::ASCII_UPPER_A + 8'd1;
      default: return soc_pkg::ASCII_LOWER_A + 8'd1;
    endcase
  endfunction

  // Shift one text byte in, compare the tail against the pattern, count
  function automatic match_result_t predict_match(input logic [soc_pkg::BYTE_W-1:0] b,
                                                  input logic eot);
    match_result_t res;
    logic hit;
    logic [soc_pkg::BYTE_W-1:0] t;
    logic [soc_pkg::BYTE_W-1:0] p;
    int k;
    int j;
    for (k = WINDOW - 1; k > 0; k--) begin
      window_bytes[k] = window_bytes[k-1];
    end
    window_bytes[0] = b;
    if (fill_count < WINDOW) fill_count++;

    hit = 1'b0;
    if (pat_len != 0 && pat_len <= WINDOW && fill_count >= pat_len) begin
      hit = 1'b1;
      for (j = 0; j < pat_len; j++) begin
        t = window_bytes[pat_len - 1 - j];
        p = pat_bytes[8*j +: 8];
        if (!exact_cmp) begin
          t = to_lower(t);
          p = to_lower(p);
        end
        if (t != p) hit = 1'b0;
      end
    end

    // A pending skip blocks the match and counts down regardless of settings
    if (skip_count != 0) begin
      hit = 1'b0;
      skip_count--;
    end else if (hit) begin
      if (match_count != '1) match_count++;
      if (no_overlap) skip_count = pat_len[soc_pkg::SKIP_W-1:0] - 4'd1;
    end

    res.hit = hit;
    res.total = match_count;
    res.done = eot;
    if (eot) begin
      window_bytes = '{default: '0};
      fill_count = '0;
      skip_count = '0;
      match_count = '0;
    end
    return res;
  endfunction

  // Leaves cfg_we high; the next word or write decides what follows
  task automatic write_reg(input soc_pkg::cfg_sel_t sel,
                           input logic [soc_pkg::CFG_DATA_W-1:0] v);
    cfg_we <= 1'b1;
    cfg_index <= sel;
    cfg_wdata <= v;
    @(posedge clk);
    case (sel)
      soc_pkg::CFG_PATTERN_LOW:  pat_bytes[63:0] = v;
      soc_pkg::CFG_PATTERN_HIGH: pat_bytes[127:64] = v;
      soc_pkg::CFG_PATTERN_LEN:  pat_len = v[soc_pkg::LEN_W-1:0];
      soc_pkg::CFG_CASE_SENS:    exact_cmp = v[0];
      soc_pkg::CFG_NON_OVERLAP:  no_overlap = v[0];
      default: ;
    endcase
  endtask

  task automatic send_word(input logic [soc_pkg::BYTE_W-1:0] b, input logic eot,
                           input logic typed, input match_result_t want);
    match_result_t got;
    cfg_we <= 1'b0;
    while ($urandom_range(99) < src_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tdata <= b;
    in_tlast <= eot;
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    got = predict_match(b, eot);
    pending_results.insert(pending_results.size(), typed ? want : got);
  endtask

  // Hold the input and let every expected word come back
  task automatic wait_idle();
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic set_idling(input int mode);
    case (mode)
      0: begin
        src_idle_pct = 38;
        sink_idle_pct = 46;
      end
      1: begin
        src_idle_pct = 46;
        sink_idle_pct = 38;
      end
      default: begin
        src_idle_pct = 0;
        sink_idle_pct = 0;
      end
    endcase
  endtask

  // Program one set of settings, then stream texts built mostly from pattern copies
  task automatic run_phase(input int p);
    logic [soc_pkg::PAT_W-1:0] pat;
    logic [soc_pkg::BYTE_W-1:0] b;
    int len;
    int span;
    int mode;
    int sent;
    int j;
    len = phase_len[p];
    for (j = 0; j < soc_pkg::PAT_BYTES; j++) begin
      pat[8*j +: 8] = (p % 3 == 2) ? soc_pkg::BYTE_W'($urandom_range(255)) : pick_letter();
    end
    set_idling(p / 4);
    write_reg(soc_pkg::CFG_PATTERN_LOW, pat[63:0]);
    write_reg(soc_pkg::CFG_PATTERN_HIGH, pat[127:64]);
    write_reg(soc_pkg::CFG_PATTERN_LEN, soc_pkg::CFG_DATA_W'(len));
    write_reg(soc_pkg::CFG_CASE_SENS, soc_pkg::CFG_DATA_W'(p % 2));
    write_reg(soc_pkg::CFG_NON_OVERLAP, soc_pkg::CFG_DATA_W'((p / 2) % 2));
    if (len > WINDOW) len = WINDOW;

    sent = 0;
    while (sent < PHASE_WORDS) begin
      mode = $urandom_range(9);
      if (mode < 6 && len != 0) begin
        span = (mode == 0) ? $urandom_range(1, len) : len;
        for (j = 0; j < span; j++) begin
          b = pat_bytes[8*j +: 8];
          if (!exact_cmp && $urandom_range(1) &&
              (b | CASE_BIT) >= soc_pkg::ASCII_LOWER_A && (b | CASE_BIT) <= ASCII_LOWER_Z) begin
            b = b ^ CASE_BIT;
          end
          if ($urandom_range(19) == 0) b = soc_pkg::BYTE_W'($urandom_range(255));
          send_word(b, $urandom_range(39) == 0, 1'b0, '0);
          sent++;
        end
      end else begin
        b = (mode == 9) ? soc_pkg::BYTE_W'($urandom_range(255)) : pick_letter();
        send_word(b, $urandom_range(39) == 0, 1'b0, '0);
        sent++;
      end
    end
    wait_idle();
  endtask

  // Accept result words, compare against the oldest expectation, watch for a hang
  always @(posedge clk) begin : result_check
    match_result_t want;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= sink_idle_pct);
      if (out_tvalid && out_tready) begin
        if (pending_results.size() == 0) begin
          $error("result word with nothing expected: tdata %h tlast %b", out_tdata, out_tlast);
          fail_count++;
        end else begin
          want = pending_results.pop_front();
          if (out_tdata[0] !== want.hit) begin
            $error("match_ends_here: expected %0d, got %0d", want.hit, out_tdata[0]);
            fail_count++;
          end
          if (out_tdata[soc_pkg::TALLY_W:1] !== want.total) begin
            $error("match_total: expected %0d, got %0d", want.total,
                   out_tdata[soc_pkg::TALLY_W:1]);
            fail_count++;
          end
          if (out_tdata[soc_pkg::OUT_TDATA_W-1:soc_pkg::TALLY_W+1] !== '0) begin
            $error("pad: expected 0, got %h",
                   out_tdata[soc_pkg::OUT_TDATA_W-1:soc_pkg::TALLY_W+1]);
            fail_count++;
          end
          if (out_tlast !== want.done) begin
            $error("text_done: expected %0d, got %0d", want.done, out_tlast);
            fail_count++;
          end
        end
      end
      if ((out_tvalid && out_tready) || (in_tvalid && in_tready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
        $display("simulation failed");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  initial begin
    match_result_t want;
    int r;
    int n;
    int p;

    // Empty pattern after reset, then a two-byte pattern with a mid-text
    // switch to folded compare, non-overlapping folded runs, the full
    // sixteen-byte pattern of all ones, and an overlong length
    plan_rows = '{
      '{ROW_WORD,  soc_pkg::CFG_PATTERN_LOW,  64'd0, 8'h00, 1'b0, 5'd1, 1'b1, 1'b0, 32'd0},
      '{ROW_WORD,  soc_pkg::CFG_PATTERN_LOW,  64'd0, 8'hFF, 1'b1, 5'd1, 1'b1, 1'b0, 32'd0},
      '{ROW_WRITE, soc_pkg::CFG_PATTERN_LOW,  64'h6241, 8'h00, 1'b0, 5'd0, 1'b0, 1'b0, 32'd0},
      '{ROW_WRITE, soc_pkg::CFG_PATTERN_LEN,  64'd2, 8'h00, 1'b0, 5'd0, 1'b0, 1'b0, 32'd0},
      '{ROW_WORD,  soc_pkg::CFG_PATTERN_LOW,  64'd0, 8'h41, 1'b0, 5'd1, 1'b1, 1'b0, 32'd0},
      '{ROW_WORD,  soc_pkg::CFG_PATTERN_LOW,  64'd0, 8'h62, 1'b0, 5'd1, 1'b1, 1'b1, 32'd1},
      '{ROW_WORD,  soc_pkg::CFG_PATTERN_LOW,  64'd0, 8'h61, 1'b0, 5'd1, 1'b1, 1'b0, 32'd1},
      '{ROW_WRITE, soc_pkg::CFG_CASE_SENS,    64'd0, 8'h00, 1'b0, 5'd0, 1'b0, 1'b0, 32'd0},
      '{ROW_WORD,  soc_pkg::CFG_PATTERN_LOW,  64'd0, 8'h42, 1'b1, 5'd1, 1'b1, 1'b1, 32'd2},
      '{ROW_WRITE, soc_pkg::CFG_PATTERN_LOW,  64'h616161, 8'h00, 1'b0, 5'd0, 1'b0, 1'b0, 32'd0},
      '{ROW_WRITE, soc_pkg::CFG_PATTERN_LEN,  64'd3, 8'h00, 1'b0, 5'd0, 1'b0, 1'b0, 32'd0},
      '{ROW_WRITE, soc_pkg::CFG_NON_OVERLAP,  64'd1, 8'h00, 1'b0, 5'd0, 1'b0, 1'b0, 32'd0},
      '{ROW_WORD,  soc_pkg::CFG_PATTERN_LOW,  64'd0, 8'h41, 1'b0, 5'd3, 1'b0, 1'b0, 32'd0},
      '{ROW_WORD,  soc_pkg::CFG_PATTERN_LOW,  64'd0, 8'h61, 1'b1, 5'd1, 1'b0, 1'b0, 32'd0},
      '{ROW_WRITE, soc_pkg::CFG_PATTERN_LOW,  '1,    8'h00, 1'b0, 5'd0, 1'b0, 1'b0, 32'd0},
      '{ROW_WRITE, soc_pkg::CFG_PATTERN_HIGH, '1,    8'h00, 1'b0, 5'd0, 1'b0, 1'b0, 32'd0},
      '{ROW_WRITE, soc_pkg::CFG_PATTERN_LEN,  64'd16, 8'h00, 1'b0, 5'd0, 1'b0, 1'b0, 32'd0},
      '{ROW_WRITE, soc_pkg::CFG_CASE_SENS,    64'd1, 8'h00, 1'b0, 5'd0, 1'b0, 1'b0, 32'd0},
      '{ROW_WRITE, soc_pkg::CFG_NON_OVERLAP,  64'd0, 8'h00, 1'b0, 5'd0, 1'b0, 1'b0, 32'd0},
      '{ROW_WORD,  soc_pkg::CFG_PATTERN_LOW,  64'd0, 8'hFF, 1'b0, 5'd15, 1'b1, 1'b0, 32'd0},
      '{ROW_WORD,  soc_pkg::CFG_PATTERN_LOW,  64'd0, 8'hFF, 1'b0, 5'd1, 1'b1, 1'b1, 32'd1},
      '{ROW_WORD,  soc_pkg::CFG_PATTERN_LOW,  64'd0, 8'hFF, 1'b1, 5'd1, 1'b1, 1'b1, 32'd2},
      '{ROW_WRITE, soc_pkg::CFG_PATTERN_LEN,  64'd31, 8'h00, 1'b0, 5'd0, 1'b0, 1'b0, 32'd0},
      '{ROW_WORD,  soc_pkg::CFG_PATTERN_LOW,  64'd0, 8'hFF, 1'b1, 5'd1, 1'b1, 1'b0, 32'd0}
    };

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Walk the directed plan
    set_idling(0);
    for (r = 0; r < $size(plan_rows); r++) begin
      if (plan_rows[r].kind == ROW_WRITE) begin
        wait_idle();
        write_reg(plan_rows[r].sel, plan_rows[r].value);
      end else begin
        want.hit = plan_rows[r].want_hit;
        want.total = plan_rows[r].want_total;
        want.done = plan_rows[r].eot;
        for (n = 0; n < plan_rows[r].reps; n++) begin
          send_word(plan_rows[r].text, plan_rows[r].eot, plan_rows[r].typed, want);
        end
      end
    end
    wait_idle();

    // Random texts over a sweep of settings and idling patterns
    for (p = 0; p < PHASES; p++) begin
      run_phase(p);
    end

    wait_idle();
    repeat (8) @(posedge clk);
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ===== substring_occurrence_counter_top.f =====
hdl/soc_pkg.sv
hdl/soc_cfg_regs.sv
hdl/soc_in_reg.sv
hdl/soc_match_core.sv
hdl/substring_occurrence_counter_top.sv
tb/sv/tb.sv
